FILE: rtl/dmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_pkg: shared types and constants of the mutual exclusion node
// Opcodes, result kinds, node modes and the command word that the front end
// hands to the back end.
// ----------------------------------------------------------------------------
package dmn_pkg;

  localparam int NODE_W   = 5;
  localparam int MASK_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int QDEPTH   = 2;   // power of two

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  localparam logic [0:0] CFG_OWN_NODE  = 1'b0;
  localparam logic [0:0] CFG_PEER_MASK = 1'b1;

  typedef enum logic [1:0] {
    OP_ENTER   = 2'd0,
    OP_GRANT   = 2'd1,
    OP_REQUEST = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_GRANT   = 2'd0,
    KIND_ENTER   = 2'd1,
    KIND_ENTERED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_REQ  = 2'd1,
    MODE_OCC  = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [NODE_W-1:0]  peer;
    logic [STAMP_W-1:0] stamp;
    logic               is_self;
    logic               peer_lt_own;
  } cmd_t;

endpackage

FILE: rtl/dmn_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_in_if: input channel of the mutual exclusion node
// Valid/ready channel carrying peer messages and local requests.
// ----------------------------------------------------------------------------
interface dmn_in_if;
  import dmn_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [NODE_W-1:0]  peer_id;
  logic [STAMP_W-1:0] stamp_in;

  modport source (output valid, output op, output peer_id, output stamp_in, input ready);
  modport sink   (input valid, input op, input peer_id, input stamp_in, output ready);
endinterface

FILE: rtl/dmn_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_out_if: result channel of the mutual exclusion node
// Valid/ready channel carrying outgoing messages and the entered event.
// ----------------------------------------------------------------------------
interface dmn_out_if;
  import dmn_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [NODE_W-1:0]  dest_node;
  logic [STAMP_W-1:0] stamp_out;
  logic               last;

  modport source (output valid, output kind, output dest_node, output stamp_out,
                  output last, input ready);
  modport sink   (input valid, input kind, input dest_node, input stamp_out,
                  input last, output ready);
endinterface

FILE: rtl/dmn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_front: input classifier
// Takes input transfers, drops messages that have no effect on the node and
// tags the rest with the peer comparisons against the own node index.
// ----------------------------------------------------------------------------
module dmn_front #(
  parameter int NODES = 32
) (
  dmn_in_if.sink                      in_if,
  input  logic [dmn_pkg::NODE_W-1:0]  own_node,
  input  logic                        q_full,
  output logic                        push,
  output dmn_pkg::cmd_t               push_cmd
);
  import dmn_pkg::*;

  localparam int NL = (NODES >= MASK_W) ? MASK_W : NODES;
  localparam logic [NODE_W:0] NL_V = (NODE_W + 1)'(NL);

  logic peer_ok;
  logic is_self;
  logic keep;
  op_e  op;

  assign op      = op_e'(in_if.op);
  assign peer_ok = {1'b0, in_if.peer_id} < NL_V;
  assign is_self = in_if.peer_id == own_node;

  // messages from unknown nodes and grants from ourselves change nothing
  always_comb begin
    unique case (op)
      OP_ENTER:   keep = peer_ok;
      OP_GRANT:   keep = peer_ok && !is_self;
      OP_REQUEST: keep = 1'b1;
      OP_RELEASE: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full && keep;

  assign push_cmd.op          = op;
  assign push_cmd.peer        = in_if.peer_id;
  assign push_cmd.stamp       = in_if.stamp_in;
  assign push_cmd.is_self     = is_self;
  assign push_cmd.peer_lt_own = in_if.peer_id < own_node;

endmodule

FILE: rtl/dmn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_queue: command queue
// Small FIFO between classifier and executor so each side stalls on its own.
// ----------------------------------------------------------------------------
module dmn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dmn_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dmn_pkg::cmd_t  head_cmd
);
  import dmn_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PW:0] DEPTH_V = (PW + 1)'(QDEPTH);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r,  count_nxt;

  assign full       = count_r == DEPTH_V;
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW + 1)'(push) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/dmn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_back: protocol executor
// Holds the Lamport clock and node state, runs one command at a time and
// walks the peer or rival mask for ENTER or GRANT, one node per cycle unless the output is full.
// ----------------------------------------------------------------------------
module dmn_back #(
  parameter int NODES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dmn_pkg::NODE_W-1:0]   own_node,
  input  logic [dmn_pkg::MASK_W-1:0]   peer_mask,
  input  logic                         q_valid,
  input  dmn_pkg::cmd_t                q_cmd,
  output logic                         pop,
  output dmn_pkg::mode_e               mode,
  dmn_out_if.source                    out_if
);
  import dmn_pkg::*;

  localparam int NL    = (NODES >= MASK_W) ? MASK_W : NODES;
  localparam int IDX_W = (NL > 1) ? $clog2(NL) : 1;
  localparam logic [NL-1:0] ONE = NL'(1);

  back_state_e        state_r, state_nxt;
  mode_e              mode_r, mode_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [STAMP_W-1:0] req_r, req_nxt;
  logic [NL-1:0]      rival_r, rival_nxt;
  logic [NL-1:0]      grant_r, grant_nxt;
  logic [NL-1:0]      work_r, work_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  kind_e              scan_kind_r, scan_kind_nxt;

  logic               out_valid_r, out_valid_nxt;
  kind_e              out_kind_r;
  logic [NODE_W-1:0]  out_dest_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic               out_last_r;

  logic               load_ok;
  logic               load;
  kind_e              ld_kind;
  logic [NODE_W-1:0]  ld_dest;
  logic [STAMP_W-1:0] ld_stamp;
  logic               ld_last;

  logic [NL-1:0]      own_oh;
  logic [NL-1:0]      peers;
  logic [NL-1:0]      peer_oh;
  logic [NL-1:0]      idx_oh;
  logic [NL-1:0]      work_clr;
  logic [NL-1:0]      grant_upd;
  logic [NL-1:0]      rival_out;
  logic [STAMP_W-1:0] clock_max;
  logic [STAMP_W-1:0] clock_seen;
  logic [STAMP_W-1:0] clock_inc;
  logic               grant_ok;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      own_oh[i] = own_node == NODE_W'(i);
    end
  end

  assign peers     = peer_mask[NL-1:0] & ~own_oh;
  assign peer_oh   = ONE << q_cmd.peer;
  assign idx_oh    = ONE << idx_r;
  assign work_clr  = work_r & ~idx_oh;
  assign grant_upd = grant_r | peer_oh;
  assign rival_out = rival_r & ~own_oh;

  // Lamport clock: max with the peer stamp plus one, saturating
  assign clock_max  = (q_cmd.stamp > clock_r) ? q_cmd.stamp : clock_r;
  assign clock_seen = (clock_max == STAMP_MAX) ? clock_max : clock_max + STAMP_W'(1);
  assign clock_inc  = (clock_r == STAMP_MAX) ? clock_r : clock_r + STAMP_W'(1);

  assign grant_ok = (mode_r == MODE_FREE) ||
                    (mode_r == MODE_REQ &&
                     (q_cmd.stamp < req_r || (q_cmd.stamp == req_r && q_cmd.peer_lt_own)));

  assign load_ok = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    clock_nxt     = clock_r;
    req_nxt       = req_r;
    rival_nxt     = rival_r;
    grant_nxt     = grant_r;
    work_nxt      = work_r;
    idx_nxt       = idx_r;
    scan_kind_nxt = scan_kind_r;
    pop           = 1'b0;
    load          = 1'b0;
    ld_kind       = KIND_GRANT;
    ld_dest       = '0;
    ld_stamp      = '0;
    ld_last       = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && load_ok) begin
          pop = 1'b1;
          unique case (q_cmd.op)
            OP_ENTER: begin
              clock_nxt = clock_seen;
              if (!q_cmd.is_self) begin
                if (grant_ok) begin
                  load    = 1'b1;
                  ld_kind = KIND_GRANT;
                  ld_dest = q_cmd.peer;
                end else begin
                  rival_nxt = rival_r | peer_oh;
                end
              end
            end
            OP_GRANT: begin
              if (mode_r == MODE_REQ) begin
                if ((grant_upd & peers) == peers) begin
                  mode_nxt  = MODE_OCC;
                  grant_nxt = '0;
                  load      = 1'b1;
                  ld_kind   = KIND_ENTERED;
                end else begin
                  grant_nxt = grant_upd;
                end
              end
            end
            OP_REQUEST: begin
              if (mode_r == MODE_FREE) begin
                clock_nxt = clock_inc;
                req_nxt   = clock_inc;
                grant_nxt = '0;
                if (peers == '0) begin
                  // nobody to ask: enter at once
                  mode_nxt = MODE_OCC;
                  load     = 1'b1;
                  ld_kind  = KIND_ENTERED;
                end else begin
                  mode_nxt      = MODE_REQ;
                  work_nxt      = peers;
                  idx_nxt       = '0;
                  scan_kind_nxt = KIND_ENTER;
                  state_nxt     = ST_SCAN;
                end
              end
            end
            OP_RELEASE: begin
              if (mode_r == MODE_OCC) begin
                mode_nxt  = MODE_FREE;
                rival_nxt = '0;
                if (rival_out != '0) begin
                  work_nxt      = rival_out;
                  idx_nxt       = '0;
                  scan_kind_nxt = KIND_GRANT;
                  state_nxt     = ST_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (work_r[idx_r]) begin
          if (load_ok) begin
            load     = 1'b1;
            ld_kind  = scan_kind_r;
            ld_dest  = NODE_W'(idx_r);
            ld_stamp = (scan_kind_r == KIND_ENTER) ? req_r : '0;
            ld_last  = work_clr == '0;
            work_nxt = work_clr;
            idx_nxt  = idx_r + IDX_W'(1);
            if (work_clr == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_FREE;
      clock_r     <= '0;
      req_r       <= '0;
      rival_r     <= '0;
      grant_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      clock_r     <= clock_nxt;
      req_r       <= req_nxt;
      rival_r     <= rival_nxt;
      grant_r     <= grant_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    idx_r       <= idx_nxt;
    scan_kind_r <= scan_kind_nxt;
    if (load) begin
      out_kind_r  <= ld_kind;
      out_dest_r  <= ld_dest;
      out_stamp_r <= ld_stamp;
      out_last_r  <= ld_last;
    end
  end

  assign mode             = mode_r;
  assign out_if.valid     = out_valid_r;
  assign out_if.kind      = out_kind_r;
  assign out_if.dest_node = out_dest_r;
  assign out_if.stamp_out = out_stamp_r;
  assign out_if.last      = out_last_r;

endmodule

FILE: rtl/distributed_mutex_node_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distributed_mutex_node_unit: Ricart-Agrawala mutual exclusion node
// Top level: configuration registers, classifier, command queue, executor.
// ----------------------------------------------------------------------------
// A peer ENTER or GRANT, or a release with no deferred rivals, passes through
// the two-entry command queue and is handled by the executor in its idle state;
// its single result, if any, shows up on the output register. A local
// request with linked peers, or a release with deferred rivals, walks the
// peer or rival mask one node per cycle in the executor's scan counter while
// the output register can take a message, and sends one message per marked
// node in ascending node order. Inputs keep being taken while the queue has
// room; results wait in a one-entry output register. Configuration writes take
// effect at the next edge and should be made while no command is in flight.
module distributed_mutex_node_unit #(
  parameter int NODES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [dmn_pkg::MASK_W-1:0]  cfg_data,
  dmn_in_if.sink                      in_if,
  dmn_out_if.source                   out_if
);
  import dmn_pkg::*;

  logic [NODE_W-1:0] own_node_r;
  logic [MASK_W-1:0] peer_mask_r;

  logic  q_full;
  logic  push;
  cmd_t  push_cmd;
  logic  pop;
  logic  q_valid;
  cmd_t  q_cmd;
  mode_e mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r  <= '0;
      peer_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_NODE:  own_node_r  <= cfg_data[NODE_W-1:0];
        CFG_PEER_MASK: peer_mask_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dmn_front #(.NODES(NODES)) u_front (
    .in_if    (in_if),
    .own_node (own_node_r),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dmn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  dmn_back #(.NODES(NODES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .own_node  (own_node_r),
    .peer_mask (peer_mask_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .mode      (mode),
    .out_if    (out_if)
  );

  // entering is always the final result of its input
  a_entered_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind == KIND_ENTERED |-> out_if.last)
    else $error("entered result without last");

  // while the entered event is pending the node holds the critical section
  a_entered_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind == KIND_ENTERED |-> mode == MODE_OCC)
    else $error("entered result while not occupied");

  // outside configuration writes, no message is addressed to this node
  a_no_self_msg: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.kind != KIND_ENTERED && !cfg_we && !$past(cfg_we)
    |-> out_if.dest_node != own_node_r)
    else $error("message addressed to own node");

endmodule

FILE: sim/mutex_node_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_node_checker: scoreboard for the mutual exclusion node
// Follows configuration writes and input transfers, keeps its own copy of the
// node state, predicts the messages the node must emit and compares each
// result transfer, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module mutex_node_checker
  import dmn_pkg::*;
#(
  parameter int NODES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [MASK_W-1:0]  cfg_data,
  dmn_in_if                  in_mon,
  dmn_out_if                 out_mon,
  output int                 pending,
  output logic [STAMP_W-1:0] req_hint,
  output int                 fail_count
);

  typedef struct packed {
    kind_e              kind;
    logic [NODE_W-1:0]  dest;
    logic [STAMP_W-1:0] stamp;
    logic               last;
  } node_msg_t;

  localparam logic [MASK_W-1:0] VALID_NODES =
    (NODES >= 32) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NODES) - 64'd1);

  logic [NODE_W-1:0]  own_node;
  logic [MASK_W-1:0]  peer_mask;
  mode_e              mode;
  logic [STAMP_W-1:0] lamport;
  logic [STAMP_W-1:0] req_stamp;
  logic [MASK_W-1:0]  rivals;
  logic [MASK_W-1:0]  grants;
  node_msg_t          awaited_msgs[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [MASK_W-1:0] linked_peers();
    return peer_mask & VALID_NODES & ~(MASK_W'(1) << own_node);
  endfunction

  function automatic void queue_msg(input kind_e kind, input logic [NODE_W-1:0] dest,
                                    input logic [STAMP_W-1:0] stamp);
    node_msg_t m;
    m.kind  = kind;
    m.dest  = dest;
    m.stamp = stamp;
    m.last  = 1'b0;
    awaited_msgs.insert(awaited_msgs.size(), m);
  endfunction

  // one message per marked node, ascending node order
  function automatic void queue_to_mask(input logic [MASK_W-1:0] mask, input kind_e kind,
                                        input logic [STAMP_W-1:0] stamp);
    for (int i = 0; i < MASK_W; i++)
      if (mask[i]) queue_msg(kind, NODE_W'(i), stamp);
  endfunction

  function automatic void enter_if_covered();
    if (mode == MODE_REQ && (grants & linked_peers()) == linked_peers()) begin
      mode   = MODE_OCC;
      grants = '0;
      queue_msg(KIND_ENTERED, '0, '0);
    end
  endfunction

  function automatic void advance_node(input op_e op, input logic [NODE_W-1:0] peer,
                                       input logic [STAMP_W-1:0] stamp);
    int                 first;
    logic [STAMP_W-1:0] raised;
    logic               give;
    node_msg_t          tail;
    first = awaited_msgs.size();
    case (op)
      OP_ENTER: begin
        if (VALID_NODES[peer]) begin
          raised  = (stamp > lamport) ? stamp : lamport;
          lamport = (raised == STAMP_MAX) ? raised : raised + 1'b1;
          // a message from this node only moves the clock
          if (peer != own_node) begin
            case (mode)
              MODE_FREE: give = 1'b1;
              MODE_REQ:  give = (stamp < req_stamp) ||
                                (stamp == req_stamp && peer < own_node);
              default:   give = 1'b0;
            endcase
            if (give) queue_msg(KIND_GRANT, peer, '0);
            else rivals[peer] = 1'b1;
          end
        end
      end
      OP_GRANT: begin
        if (VALID_NODES[peer] && peer != own_node && mode == MODE_REQ) begin
          grants[peer] = 1'b1;
          enter_if_covered();
        end
      end
      OP_REQUEST: begin
        if (mode == MODE_FREE) begin
          if (lamport != STAMP_MAX) lamport = lamport + 1'b1;
          req_stamp = lamport;
          mode      = MODE_REQ;
          grants    = '0;
          queue_to_mask(linked_peers(), KIND_ENTER, req_stamp);
          enter_if_covered();
        end
      end
      default: begin
        if (mode == MODE_OCC) begin
          mode = MODE_FREE;
          queue_to_mask(rivals & VALID_NODES & ~(MASK_W'(1) << own_node), KIND_GRANT, '0);
          rivals = '0;
        end
      end
    endcase
    if (awaited_msgs.size() > first) begin
      tail      = awaited_msgs[awaited_msgs.size() - 1];
      tail.last = 1'b1;
      awaited_msgs[awaited_msgs.size() - 1] = tail;
    end
  endfunction

  always @(posedge clk) begin
    node_msg_t want;
    if (!rst_n) begin
      own_node   = '0;
      peer_mask  = '0;
      mode       = MODE_FREE;
      lamport    = '0;
      req_stamp  = '0;
      rivals     = '0;
      grants     = '0;
      fail_count = 0;
      awaited_msgs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OWN_NODE) own_node = cfg_data[NODE_W-1:0];
        else peer_mask = cfg_data;
      end
      // compare before predicting: a result never belongs to an item taken this edge
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_msgs.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d dest %0d stamp %h last %b",
                                    out_mon.kind, out_mon.dest_node, out_mon.stamp_out,
                                    out_mon.last));
        end else begin
          want = awaited_msgs.pop_front();
          if (out_mon.kind !== want.kind || out_mon.dest_node !== want.dest ||
              out_mon.stamp_out !== want.stamp || out_mon.last !== want.last)
            report_mismatch($sformatf(
              "got kind %0d dest %0d stamp %h last %b, want kind %0d dest %0d stamp %h last %b",
              out_mon.kind, out_mon.dest_node, out_mon.stamp_out, out_mon.last,
              want.kind, want.dest, want.stamp, want.last));
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_node(op_e'(in_mon.op), in_mon.peer_id, in_mon.stamp_in);
    end
    pending  <= awaited_msgs.size();
    req_hint <= req_stamp;
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top of the mutual exclusion node simulation
// Drives configuration and message traffic: a directed pass over the protocol
// corners, then request/grant/release rounds with random contention under
// several node ids and peer masks, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import dmn_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;   // longest scan plus output register

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [0:0]         cfg_index  = CFG_OWN_NODE;
  logic [MASK_W-1:0]  cfg_data   = '0;
  logic               in_valid   = 1'b0;
  op_e                in_op      = OP_ENTER;
  logic [NODE_W-1:0]  in_peer    = '0;
  logic [STAMP_W-1:0] in_stamp   = '0;
  logic               sink_ready = 1'b0;

  int                 pending;
  int                 fail_count;
  logic [STAMP_W-1:0] req_hint;

  logic               src_idle_en  = 1'b1;
  logic               sink_idle_en = 1'b1;
  int                 stall_left   = 0;
  int                 sent_items   = 0;
  logic [NODE_W-1:0]  cur_own      = '0;
  logic [MASK_W-1:0]  cur_mask     = '0;

  dmn_in_if  in_ch();
  dmn_out_if out_ch();

  assign in_ch.valid    = in_valid;
  assign in_ch.op       = in_op;
  assign in_ch.peer_id  = in_peer;
  assign in_ch.stamp_in = in_stamp;
  assign out_ch.ready   = sink_ready;

  distributed_mutex_node_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  mutex_node_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .pending    (pending),
    .req_hint   (req_hint),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure, in bursts started at random
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 16);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // valid stays high from one item to the next unless a gap is inserted
  task automatic send_item(input op_e op, input logic [NODE_W-1:0] peer,
                           input logic [STAMP_W-1:0] stamp);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_peer  <= peer;
    in_stamp <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [NODE_W-1:0] own, input logic [MASK_W-1:0] mask);
    wait_drained();
    // ignored items leave no result to wait for, so give the scan time to finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_NODE;
    cfg_data  <= MASK_W'(own);
    @(posedge clk);
    cfg_index <= CFG_PEER_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_own  = own;
    cur_mask = mask;
  endtask

  // stamps near the current request stamp hit the tie-break and both sides of it
  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 6))
      0:       return $urandom;
      1:       return req_hint;
      2:       return req_hint - 1'b1;
      3:       return req_hint + 1'b1;
      4:       return STAMP_W'($urandom_range(0, 64));
      default: return req_hint + STAMP_W'($urandom_range(0, 8)) - STAMP_W'(4);
    endcase
  endfunction

  task automatic send_noise();
    send_item(op_e'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 31)), pick_stamp());
  endtask

  task automatic run_round();
    logic [NODE_W-1:0] grant_order[$];
    logic [NODE_W-1:0] swap;
    int                j;
    for (int i = 0; i < MASK_W; i++)
      if (cur_mask[i] && NODE_W'(i) != cur_own)
        grant_order.insert(grant_order.size(), NODE_W'(i));
    for (int i = grant_order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap           = grant_order[i];
      grant_order[i] = grant_order[j];
      grant_order[j] = swap;
    end
    repeat ($urandom_range(0, 2)) send_noise();
    send_item(OP_REQUEST, NODE_W'($urandom_range(0, 31)), $urandom);
    while (grant_order.size() != 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_item(OP_GRANT, grant_order.pop_front(), $urandom);
        6, 7:             send_item(OP_ENTER, NODE_W'($urandom_range(0, 31)), pick_stamp());
        8:                send_item(OP_GRANT, NODE_W'($urandom_range(0, 31)), $urandom);
        default:          send_noise();
      endcase
    end
    // contenders arriving while occupied become rivals
    repeat ($urandom_range(0, 3))
      send_item(OP_ENTER, NODE_W'($urandom_range(0, 31)), pick_stamp());
    if ($urandom_range(0, 7) != 0) send_item(OP_RELEASE, NODE_W'($urandom_range(0, 31)), $urandom);
  endtask

  task automatic run_phase(input logic [NODE_W-1:0] own, input logic [MASK_W-1:0] mask,
                           input int quota, input logic src_en, input logic sink_en,
                           input logic hold_off, input logic saturate);
    reconfigure(own, mask);
    src_idle_en  = src_en;
    sink_idle_en = sink_en;
    if (saturate) send_item(OP_ENTER, NODE_W'($urandom_range(0, 31)), STAMP_MAX);
    sent_items = 0;
    while (sent_items < quota) begin
      run_round();
      if (hold_off && $urandom_range(0, 2) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // node 5 linked to 0, 3, 9 and 31; own bit set and ignored
    reconfigure(NODE_W'(5), 32'h8000_0229);
    send_item(OP_GRANT, NODE_W'(3), '0);     // grant while free
    send_item(OP_RELEASE, '0, '0);           // release while free
    send_item(OP_ENTER, NODE_W'(3), '0);     // free: granted at once
    send_item(OP_ENTER, NODE_W'(5), '0);     // from own node: clock only
    send_item(OP_REQUEST, '0, '0);
    send_item(OP_REQUEST, '0, '0);           // already requesting
    send_item(OP_ENTER, NODE_W'(0), 32'd3);  // equal stamp, lower id
    send_item(OP_ENTER, NODE_W'(9), 32'd3);  // equal stamp, higher id
    send_item(OP_ENTER, NODE_W'(31), 32'd2); // lower stamp
    send_item(OP_ENTER, NODE_W'(3), 32'd100);
    send_item(OP_GRANT, NODE_W'(5), '0);     // grant from own node
    send_item(OP_GRANT, NODE_W'(0), '0);
    send_item(OP_GRANT, NODE_W'(3), '0);
    send_item(OP_GRANT, NODE_W'(9), '0);
    send_item(OP_GRANT, NODE_W'(31), '0);
    send_item(OP_ENTER, NODE_W'(0), '0);     // occupied: deferred
    send_item(OP_REQUEST, '0, '0);           // request while occupied
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_ENTER, NODE_W'(1), '0);     // unlinked peer, free
    // peer mask shrinks while requesting
    reconfigure('0, 32'h0000_0006);
    send_item(OP_REQUEST, '0, '0);
    send_item(OP_GRANT, NODE_W'(1), '0);
    reconfigure('0, 32'h0000_0002);
    send_item(OP_GRANT, NODE_W'(2), '0);
    send_item(OP_RELEASE, '0, '0);
    // no linked peers: request enters at once
    reconfigure('0, 32'h0000_0001);
    send_item(OP_REQUEST, '0, '0);
    send_item(OP_RELEASE, '0, '0);

    run_phase('0, '0, 50, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(NODE_W'(31), {MASK_W{1'b1}}, 110, 1'b0, 1'b1, 1'b0, 1'b0);
    run_phase(NODE_W'($urandom_range(0, 31)), $urandom, 90, 1'b1, 1'b0, 1'b1, 1'b0);
    run_phase(NODE_W'($urandom_range(0, 31)), $urandom & $urandom & $urandom, 70,
              1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(NODE_W'($urandom_range(0, 31)), $urandom, 80, 1'b1, 1'b1, 1'b1, 1'b0);
    // clock pinned at its maximum, no idling on either side
    run_phase(NODE_W'($urandom_range(0, 31)), $urandom, 80, 1'b0, 1'b0, 1'b0, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dmn_pkg.sv
rtl/dmn_in_if.sv
rtl/dmn_out_if.sv
rtl/dmn_front.sv
rtl/dmn_queue.sv
rtl/dmn_back.sv
rtl/distributed_mutex_node_unit.sv
sim/mutex_node_checker.sv
sim/testbench.sv
